>>> src/sof_pkg.sv
`timescale 1ns / 1ps
package sof_pkg;

    localparam int VALUE_DEPTH   = 256;
    localparam int FRAME_DEPTH   = 32;
    localparam int MAX_FRAME_LEN = 32;

    localparam int VA_W = $clog2(VALUE_DEPTH);
    localparam int VC_W = $clog2(VALUE_DEPTH + 1);
    localparam int FA_W = $clog2(FRAME_DEPTH);
    localparam int FC_W = $clog2(FRAME_DEPTH + 1);
    localparam int OL_W = $clog2(MAX_FRAME_LEN + 1);

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_CLOSE  = 2'd1,
        OP_POP    = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_VALUE       = 2'd0,
        ST_EMPTY_FRAME = 2'd1,
        ST_EMPTY_STACK = 2'd2,
        ST_OVERFLOW    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FRAME,
        S_STREAM
    } t_state;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_value;
        t_status            status;
        logic               last;
    } t_out_item;

endpackage

>>> src/sof_ram.sv
`timescale 1ns / 1ps
module sof_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/sof_ctrl.sv
`timescale 1ns / 1ps
module sof_ctrl
    import sof_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_item           i_item,
    output t_out_item          o_result,
    output logic               o_strobe,
    // value memory
    output logic               o_v_we,
    output logic [VA_W-1:0]    o_v_waddr,
    output logic [31:0]        o_v_wdata,
    output logic [VA_W-1:0]    o_v_raddr,
    input  logic [31:0]        i_v_rdata,
    // frame start memory
    output logic               o_f_we,
    output logic [FA_W-1:0]    o_f_waddr,
    output logic [VC_W-1:0]    o_f_wdata,
    output logic [FA_W-1:0]    o_f_raddr,
    input  logic [VC_W-1:0]    i_f_rdata
);

    t_state           r_state, n_state;
    logic [VC_W-1:0]  r_vc, n_vc;
    logic [FC_W-1:0]  r_fc, n_fc;
    logic [OL_W-1:0]  r_ol, n_ol;
    logic [VC_W-1:0]  r_rd_idx, n_rd_idx;
    logic [VC_W-1:0]  r_remain, n_remain;
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status, n_out_status;
    logic             r_out_last, n_out_last;

    logic             accept;
    logic [VC_W-1:0]  vc_base;
    logic [VC_W-1:0]  start_c;
    logic [VC_W-1:0]  len;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign vc_base = r_vc - VC_W'(r_ol);
    // clamp the frame start to the held values
    assign start_c = (i_f_rdata > r_vc) ? r_vc : i_f_rdata;
    assign len     = r_vc - start_c;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_item.op == OP_POP && r_fc != '0) begin
                    n_state = S_FRAME;
                end
            end
            S_FRAME: begin
                if (len <= VC_W'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_STREAM;
                end
            end
            S_STREAM: begin
                if (r_remain == VC_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_vc         = r_vc;
        n_fc         = r_fc;
        n_ol         = r_ol;
        n_rd_idx     = r_rd_idx;
        n_remain     = r_remain;
        n_out_valid  = 1'b0;
        n_out_status = ST_VALUE;
        n_out_last   = 1'b1;
        o_v_we       = 1'b0;
        o_v_waddr    = r_vc[VA_W-1:0];
        o_v_wdata    = i_item.value;
        o_v_raddr    = r_rd_idx[VA_W-1:0];
        o_f_we       = 1'b0;
        o_f_waddr    = r_fc[FA_W-1:0];
        o_f_wdata    = vc_base;
        o_f_raddr    = FA_W'(r_fc - FC_W'(1));
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.op)
                        OP_APPEND: begin
                            if (r_ol >= OL_W'(MAX_FRAME_LEN) ||
                                r_vc >= VC_W'(VALUE_DEPTH)) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_OVERFLOW;
                            end else begin
                                o_v_we = 1'b1;
                                n_vc   = r_vc + VC_W'(1);
                                n_ol   = r_ol + OL_W'(1);
                            end
                        end
                        OP_CLOSE: begin
                            if (r_fc >= FC_W'(FRAME_DEPTH)) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_OVERFLOW;
                            end else begin
                                o_f_we = 1'b1;
                                n_fc   = r_fc + FC_W'(1);
                                n_ol   = '0;
                            end
                        end
                        OP_POP: begin
                            // drop the open values, then take the top frame
                            n_vc = vc_base;
                            n_ol = '0;
                            if (r_fc == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY_STACK;
                            end else begin
                                n_fc = r_fc - FC_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FRAME: begin
                n_vc = start_c;
                if (len == '0) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_EMPTY_FRAME;
                end else begin
                    o_v_raddr   = start_c[VA_W-1:0];
                    n_rd_idx    = start_c + VC_W'(1);
                    n_remain    = len - VC_W'(1);
                    n_out_valid = 1'b1;
                    n_out_last  = (len == VC_W'(1));
                end
            end
            S_STREAM: begin
                n_rd_idx    = r_rd_idx + VC_W'(1);
                n_remain    = r_remain - VC_W'(1);
                n_out_valid = 1'b1;
                n_out_last  = (r_remain == VC_W'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vc        <= '0;
            r_fc        <= '0;
            r_ol        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vc        <= n_vc;
            r_fc        <= n_fc;
            r_ol        <= n_ol;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_remain     <= n_remain;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    // value results take the memory read data, which lands with the strobe
    assign o_strobe           = r_out_valid;
    assign o_result.out_value = (r_out_status == ST_VALUE) ? i_v_rdata : '0;
    assign o_result.status    = r_out_status;
    assign o_result.last      = r_out_last;

endmodule

>>> src/stack_of_value_frames.sv
`timescale 1ns / 1ps
// Frame stack: append (op 0) and close (op 1) requests leave the block idle and
// may follow back to back. A pop (op 2) reads the frame start memory in its
// accept cycle, then reads the value memory once per cycle, so a pop of a frame
// of N values holds busy in S_FRAME and then S_STREAM until it has issued its
// last value read, and delivers its values on consecutive cycles, each strobe
// registered with its read data. Status results (overflow, empty stack) appear
// in the cycle after the request; an empty frame result is registered from the
// S_FRAME state. Every result is a one-cycle strobe that the receiver must take as it comes.
module stack_of_value_frames
    import sof_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output t_out_item o_result,
    output logic      o_strobe
);

    logic            v_we;
    logic [VA_W-1:0] v_waddr;
    logic [31:0]     v_wdata;
    logic [VA_W-1:0] v_raddr;
    logic [31:0]     v_rdata;
    logic            f_we;
    logic [FA_W-1:0] f_waddr;
    logic [VC_W-1:0] f_wdata;
    logic [FA_W-1:0] f_raddr;
    logic [VC_W-1:0] f_rdata;

    sof_ram #(
        .WIDTH(32),
        .DEPTH(VALUE_DEPTH)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    sof_ram #(
        .WIDTH(VC_W),
        .DEPTH(FRAME_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    sof_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .o_result  (o_result),
        .o_strobe  (o_strobe),
        .o_v_we    (v_we),
        .o_v_waddr (v_waddr),
        .o_v_wdata (v_wdata),
        .o_v_raddr (v_raddr),
        .i_v_rdata (v_rdata),
        .o_f_we    (f_we),
        .o_f_waddr (f_waddr),
        .o_f_wdata (f_wdata),
        .o_f_raddr (f_raddr),
        .i_f_rdata (f_rdata)
    );

endmodule
